// ===== design/wrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants of the weighted range partitioner.
// ----------------------------------------------------------------------------
package wrp_pkg;

   localparam int FRAC_BITS        = 32;
   localparam int MAX_REDUCERS_DEF = 8;
   localparam int DIV_W            = FRAC_BITS + 64;
   localparam int CNT_W            = 4;
   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd4;

   localparam logic [1:0] REQ_MAP    = 2'd0;
   localparam logic [1:0] REQ_REPORT = 2'd1;
   localparam logic [1:0] REQ_REINIT = 2'd2;

   localparam logic [1:0] MODE_FULL  = 2'd0;
   localparam logic [1:0] MODE_LOWER = 2'd1;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_DONE   = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] hash_value;
      logic [1:0]  range_mode;
      logic [2:0]  reducer_index;
      logic [31:0] runtime;
      logic        last_report;
   } wrp_req_item_type;

   typedef struct packed {
      logic [2:0] reducer;
      logic       result_kind;
   } wrp_rsp_item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [63:0]      divisor;
   } wrp_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [63:0]      remainder;
   } wrp_div_rsp_type;

endpackage

// ===== design/weighted_range_partitioner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_range_partitioner_unit
// Maps hashes to reducers through stored bounds; rebalances on runtime reports, splits evenly on reinit.
// ----------------------------------------------------------------------------
// One item at a time; req_ready is low while an item is in work. A lookup
// compares the hash with one stored bound per cycle, bounds 1 to n-1, n =
// reducer count. A non-final report only stores its runtime. A rebalance
// runs on the bit-serial divider shared by all divisions, DIV_W = 96; a
// reinit runs one division, then refills all MAX_REDUCERS entries. After
// reset the block runs a reinit before it first raises req_ready.
module weighted_range_partitioner_unit #(
   parameter int MAX_REDUCERS = wrp_pkg::MAX_REDUCERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wrp_pkg::wrp_req_item_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wrp_pkg::wrp_rsp_item_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [wrp_pkg::CNT_W-1:0] csr_data
);
   import wrp_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int IW = (MAX_REDUCERS > 2) ? $clog2(MAX_REDUCERS) : 1;
   localparam int NW = ($clog2(MAX_REDUCERS + 1) > CNT_W) ? $clog2(MAX_REDUCERS + 1) : CNT_W;
   localparam int AW = F + IW + 2;
   localparam int PW = F + 33;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_LOOKUP = 11'b00000000010,
      ST_SUMT   = 11'b00000000100,
      ST_SHARE  = 11'b00000001000,
      ST_MUL    = 11'b00000010000,
      ST_SDIV   = 11'b00000100000,
      ST_WDIV   = 11'b00000100000 << 1,
      ST_BOUND  = 11'b00010000000,
      ST_RDIV   = 11'b00100000000,
      ST_RFILL  = 11'b01000000000,
      ST_EMIT   = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic             boot_ff, boot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [F-1:0]     bound_ff [MAX_REDUCERS];
   logic [F-1:0]     bound_in [MAX_REDUCERS];
   logic [F:0]       weight_ff [MAX_REDUCERS];
   logic [F:0]       weight_in [MAX_REDUCERS];
   logic [31:0]      rt_ff [MAX_REDUCERS];
   logic [31:0]      rt_in [MAX_REDUCERS];
   logic [63:0]      share_ff [MAX_REDUCERS];
   logic [63:0]      share_in [MAX_REDUCERS];
   logic [31:0]      total_ff, total_in;
   logic [63:0]      ssum_ff, ssum_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [NW-1:0]    i_ff, i_in;
   logic [2:0]       hits_ff, hits_in;
   logic [63:0]      hash_ff, hash_in;
   logic [1:0]       mode_ff, mode_in;
   logic             kind_ff, kind_in;
   logic [AW-1:0]    acc_ff, acc_in;
   logic [F:0]       wq_ff, wq_in;
   logic [NW:0]      r0_ff, r0_in;
   logic [NW:0]      ar_ff, ar_in;
   logic             div_run_ff, div_run_in;
   logic             rsp_valid_ff, rsp_valid_in;
   wrp_rsp_item_type rsp_data_ff, rsp_data_in;

   wrp_div_req_type  div_req;
   wrp_div_rsp_type  div_rsp;

   logic [NW-1:0]    n_val;
   logic [IW-1:0]    idx;
   logic [IW-1:0]    idx_prev;
   logic             req_fire;
   logic [F-1:0]     bsel;
   logic [F:0]       b2;
   logic [F:0]       xv;
   logic             above;
   logic [F:0]       rh;
   logic [63:0]      rl;
   logic [32:0]      tsum;
   logic [64:0]      ssum_add;
   logic [63:0]      sval;
   logic [NW:0]      ar_sum;

   wrp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (count_ff < CNT_W'(2)) begin
         n_val = NW'(2);
      end else if (NW'(count_ff) > NW'(MAX_REDUCERS)) begin
         n_val = NW'(MAX_REDUCERS);
      end else begin
         n_val = NW'(count_ff);
      end
   end

   assign idx       = i_ff[IW-1:0];
   assign idx_prev  = IW'(i_ff - 1'b1);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = (state_ff == ST_IDLE);

   // exact compare of hash/(2^64-1) against x/2^F
   always_comb begin
      bsel  = bound_ff[idx];
      b2    = {bsel, 1'b0};
      above = 1'b0;
      if (mode_ff == MODE_FULL) begin
         xv = {1'b0, bsel};
      end else if (mode_ff == MODE_LOWER) begin
         xv = b2;
      end else begin
         xv = {1'b0, b2[F-1:0]};
      end
      rh = '0;
      rl = '0;
      if (xv != '0) begin
         rh = xv - 1'b1;
         rl = 64'(0) - 64'(xv);
      end
      above = {1'b0, hash_ff[63:64-F], hash_ff[63-F:0], {F{1'b0}}} > {rh, rl};
      if (mode_ff != MODE_FULL && mode_ff != MODE_LOWER && !b2[F]) begin
         above = 1'b1;
      end
   end

   always_comb begin
      div_req.start    = ((state_ff == ST_SDIV) || (state_ff == ST_WDIV) ||
                          (state_ff == ST_RDIV)) && !div_run_ff && !div_rsp.done;
      div_req.dividend = DIV_W'(prod_ff);
      div_req.divisor  = 64'(rt_ff[idx]);
      if (state_ff == ST_WDIV) begin
         div_req.dividend = {share_ff[idx], {F{1'b0}}};
         div_req.divisor  = ssum_ff;
      end else if (state_ff == ST_RDIV) begin
         div_req.dividend = DIV_W'(1) << F;
         div_req.divisor  = 64'(n_val);
      end
   end

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      count_in     = count_ff;
      bound_in     = bound_ff;
      weight_in    = weight_ff;
      rt_in        = rt_ff;
      share_in     = share_ff;
      total_in     = total_ff;
      ssum_in      = ssum_ff;
      prod_in      = prod_ff;
      i_in         = i_ff;
      hits_in      = hits_ff;
      hash_in      = hash_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      acc_in       = acc_ff;
      wq_in        = wq_ff;
      r0_in        = r0_ff;
      ar_in        = ar_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_run_in   = div_run_ff;
      tsum         = {1'b0, total_ff} + {1'b0, rt_ff[idx]};
      sval         = 64'(weight_ff[idx]);
      if (state_ff == ST_SDIV) begin
         sval = (div_rsp.quotient[DIV_W-1:64] != '0) ? '1 : div_rsp.quotient[63:0];
      end
      ssum_add     = {1'b0, ssum_ff} + {1'b0, sval};
      ar_sum       = ar_ff + r0_ff;

      if (div_req.start) begin
         div_run_in = 1'b1;
      end
      if (div_rsp.done) begin
         div_run_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  REQ_MAP: begin
                     hash_in  = req_data.hash_value;
                     mode_in  = req_data.range_mode;
                     i_in     = NW'(1);
                     hits_in  = '0;
                     state_in = ST_LOOKUP;
                  end
                  REQ_REPORT: begin
                     if (NW'(req_data.reducer_index) < n_val) begin
                        rt_in[IW'(req_data.reducer_index)] = req_data.runtime;
                     end
                     if (req_data.last_report) begin
                        i_in     = '0;
                        total_in = '0;
                        state_in = ST_SUMT;
                     end
                  end
                  REQ_REINIT: begin
                     state_in = ST_RDIV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (i_ff < n_val) begin
               if (above) begin
                  hits_in = hits_ff + 1'b1;
               end
               i_in = i_ff + 1'b1;
            end else begin
               kind_in  = KIND_LOOKUP;
               state_in = ST_EMIT;
            end
         end
         ST_SUMT: begin
            if (i_ff < n_val) begin
               total_in = tsum[32] ? '1 : tsum[31:0];
               i_in     = i_ff + 1'b1;
            end else begin
               i_in     = '0;
               ssum_in  = '0;
               state_in = ST_SHARE;
            end
         end
         ST_SHARE: begin
            if (i_ff < n_val) begin
               if (rt_ff[idx] == '0) begin
                  share_in[idx] = sval;
                  ssum_in       = ssum_add[64] ? '1 : ssum_add[63:0];
                  i_in          = i_ff + 1'b1;
               end else begin
                  state_in = ST_MUL;
               end
            end else if (ssum_ff == '0) begin
               kind_in  = KIND_DONE;
               state_in = ST_EMIT;
            end else begin
               i_in     = '0;
               state_in = ST_WDIV;
            end
         end
         ST_MUL: begin
            prod_in  = weight_ff[idx] * total_ff;
            state_in = ST_SDIV;
         end
         ST_SDIV: begin
            if (div_rsp.done) begin
               share_in[idx] = sval;
               ssum_in       = ssum_add[64] ? '1 : ssum_add[63:0];
               i_in          = i_ff + 1'b1;
               state_in      = ST_SHARE;
            end
         end
         ST_WDIV: begin
            if (div_rsp.done) begin
               weight_in[idx] = div_rsp.quotient[F:0];
               if (i_ff == n_val - 1'b1) begin
                  i_in     = NW'(1);
                  acc_in   = '0;
                  state_in = ST_BOUND;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_BOUND: begin
            bound_in[0] = '0;
            if (i_ff < n_val) begin
               acc_in        = acc_ff + AW'(weight_ff[idx_prev]);
               bound_in[idx] = (acc_in > AW'({F{1'b1}})) ? '1 : acc_in[F-1:0];
               i_in          = i_ff + 1'b1;
            end else begin
               kind_in  = KIND_DONE;
               state_in = ST_EMIT;
            end
         end
         ST_RDIV: begin
            if (div_rsp.done) begin
               wq_in    = div_rsp.quotient[F:0];
               r0_in    = div_rsp.remainder[NW:0];
               i_in     = '0;
               acc_in   = '0;
               ar_in    = '0;
               state_in = ST_RFILL;
            end
         end
         ST_RFILL: begin
            if (i_ff < NW'(MAX_REDUCERS)) begin
               if (i_ff < n_val) begin
                  bound_in[idx]  = acc_ff[F-1:0];
                  weight_in[idx] = wq_ff;
               end else begin
                  bound_in[idx]  = '0;
                  weight_in[idx] = '0;
               end
               rt_in[idx] = '0;
               if (ar_sum >= {1'b0, n_val}) begin
                  ar_in  = ar_sum - {1'b0, n_val};
                  acc_in = acc_ff + AW'(wq_ff) + 1'b1;
               end else begin
                  ar_in  = ar_sum;
                  acc_in = acc_ff + AW'(wq_ff);
               end
               i_in = i_ff + 1'b1;
            end else begin
               total_in = '0;
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  kind_in  = KIND_DONE;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.reducer     = (kind_ff == KIND_DONE) ? 3'd0 : hits_ff;
               rsp_data_in.result_kind = kind_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RDIV;
         boot_ff      <= 1'b1;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         div_run_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         div_run_ff   <= div_run_in;
      end
      bound_ff    <= bound_in;
      weight_ff   <= weight_in;
      rt_ff       <= rt_in;
      share_ff    <= share_in;
      total_ff    <= total_in;
      ssum_ff     <= ssum_in;
      prod_ff     <= prod_in;
      i_ff        <= i_in;
      hits_ff     <= hits_in;
      hash_ff     <= hash_in;
      mode_ff     <= mode_in;
      kind_ff     <= kind_in;
      acc_ff      <= acc_in;
      wq_ff       <= wq_in;
      r0_ff       <= r0_in;
      ar_ff       <= ar_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/wrp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_div
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per divide.
// ----------------------------------------------------------------------------
module wrp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  wrp_pkg::wrp_div_req_type div_req,
   output wrp_pkg::wrp_div_rsp_type div_rsp
);
   import wrp_pkg::*;

   localparam int SW = $clog2(DIV_W + 1);

   logic [63:0]      rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [63:0]      dvs_ff, dvs_in;
   logic [SW-1:0]    step_ff, step_in;
   logic             done_ff, done_in;
   logic [64:0]      trial;
   logic [64:0]      diff;
   logic             ge;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         step_in = SW'(DIV_W);
      end else if (step_ff != '0) begin
         rem_in  = ge ? diff[63:0] : trial[63:0];
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== design/wrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_checker
// Port-level checks of the weighted range partitioner.
// ----------------------------------------------------------------------------
module wrp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input wrp_pkg::wrp_rsp_item_type rsp_data
);
   import wrp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_DONE |-> rsp_data.reducer == 3'd0)
      else $error("completion item carries a reducer");

   a_boot_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready right after reset");

endmodule

bind weighted_range_partitioner_unit wrp_checker u_wrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
